### sv/efdb_pkg.sv
// Package for the event frame decay buffer.
// Pixel and component widths, opcodes, register indexes and reset colors.
// No dependencies.
package efdb_pkg;

  localparam int FRAME_SIZE_DEF = 128;
  localparam int COORD_W        = 7;
  localparam int COMP_W         = 8;
  localparam int NUM_COMP       = 3;
  localparam int PIX_W          = COMP_W * NUM_COMP;
  localparam int CFG_IDX_W      = 3;

  typedef logic [PIX_W-1:0]  pixel_t;
  typedef logic [COMP_W-1:0] comp_t;

  typedef enum logic [1:0] {
    OP_PAINT = 2'd0,
    OP_DECAY = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_ID0_ON  = 3'd0,
    REG_COLOR_ID0_OFF = 3'd1,
    REG_COLOR_ID1_ON  = 3'd2,
    REG_COLOR_ID1_OFF = 3'd3,
    REG_BACKGROUND    = 3'd4,
    REG_DECAY_STEP    = 3'd5
  } reg_idx_t;

  localparam pixel_t RST_COLOR_ID0 = 24'hFF0000;
  localparam pixel_t RST_COLOR_ID1 = 24'h00FFFF;
  localparam pixel_t RST_BACKGROUND = 24'h000000;
  localparam comp_t  RST_DECAY_STEP = 8'd24;

endpackage

### sv/event_frame_decay_buffer.sv
// Top level of the event frame decay buffer: pixel memory, sweep sequencer,
// configuration registers. Uses efdb_pkg and efdb_pixel_decay.
//
//   channel  | ports                                   | transaction
//   ---------+-----------------------------------------+---------------------------
//   input    | start, busy, in_opcode .. in_polarity    | start high while busy low
//   result   | out_valid, out_red/green/blue            | out_valid high, one cycle
//   config   | cfg_we, cfg_index, cfg_wdata             | cfg_we high
//
// After reset a clearing pass writes black over the frame with busy high.
// Paint and read transactions may follow every cycle while busy is low; a
// read result appears in the cycle after it is accepted. A decay sweep keeps
// busy high while it does one read-modify-write of a pixel per cycle through
// the memory's single write port. The receiver cannot stall results.
module event_frame_decay_buffer
  import efdb_pkg::*;
#(
  parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_opcode,
  input  logic [COORD_W-1:0]   in_x_coord,
  input  logic [COORD_W-1:0]   in_y_coord,
  input  logic [7:0]           in_sensor_id,
  input  logic                 in_polarity,
  output logic                 out_valid,
  output logic [COMP_W-1:0]    out_red,
  output logic [COMP_W-1:0]    out_green,
  output logic [COMP_W-1:0]    out_blue,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PIX_W-1:0]     cfg_wdata
);

  localparam int DEPTH = FRAME_SIZE * FRAME_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(FRAME_SIZE);
  localparam int IW    = (CW > COORD_W) ? CW : COORD_W;
  localparam logic [IW:0]   FS_V   = (IW+1)'(FRAME_SIZE);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP
  } state_t;

  state_t          state_r;
  logic [AW-1:0]   cnt_r;
  logic            sw_valid_r;
  logic [AW-1:0]   sw_addr_r;
  logic            out_valid_r;
  logic            out_zero_r;
  pixel_t          rd_data_r;

  pixel_t          color_id0_on_r;
  pixel_t          color_id0_off_r;
  pixel_t          color_id1_on_r;
  pixel_t          color_id1_off_r;
  pixel_t          background_r;
  comp_t           decay_step_r;

  pixel_t          mem [DEPTH];

  logic            accept;
  op_t             op;
  logic [IW:0]     x_ext;
  logic [IW:0]     y_ext;
  logic            in_frame;
  logic [IW:0]     row_full;
  logic [AW-1:0]   in_addr;
  pixel_t          paint_color;
  pixel_t          decayed;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  pixel_t          mem_wdata;
  logic [AW-1:0]   mem_raddr;

  assign busy   = (state_r != ST_IDLE) || sw_valid_r;
  assign accept = start && !busy;
  assign op     = op_t'(in_opcode);

  assign x_ext    = (IW+1)'(in_x_coord);
  assign y_ext    = (IW+1)'(in_y_coord);
  assign in_frame = (x_ext < FS_V) && (y_ext < FS_V);
  assign row_full = FS_V - (IW+1)'(1) - y_ext;
  assign in_addr  = AW'(row_full[CW-1:0]) * AW'(FRAME_SIZE) + AW'(in_x_coord);

  always_comb begin
    if (in_sensor_id == 8'd0) begin
      paint_color = in_polarity ? color_id0_on_r : color_id0_off_r;
    end else begin
      paint_color = in_polarity ? color_id1_on_r : color_id1_off_r;
    end
  end

  efdb_pixel_decay u_decay (
    .pix_in     (rd_data_r),
    .background (background_r),
    .step       (decay_step_r),
    .pix_out    (decayed)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = in_addr;
    mem_wdata = paint_color;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r;
      mem_wdata = '0;
    end else if (sw_valid_r) begin
      mem_we    = 1'b1;
      mem_waddr = sw_addr_r;
      mem_wdata = decayed;
    end else if (accept && op == OP_PAINT && in_frame) begin
      mem_we    = 1'b1;
    end
  end

  assign mem_raddr = (state_r == ST_SWEEP) ? cnt_r : in_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      sw_valid_r  <= 1'b0;
      sw_addr_r   <= '0;
      out_valid_r <= 1'b0;
      out_zero_r  <= 1'b0;
    end else begin
      sw_valid_r  <= (state_r == ST_SWEEP);
      sw_addr_r   <= cnt_r;
      out_valid_r <= accept && op == OP_READ;
      out_zero_r  <= !in_frame;
      case (state_r)
        ST_CLEAR: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == LAST_A) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          cnt_r <= '0;
          if (accept && op == OP_DECAY) begin
            state_r <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          cnt_r <= cnt_r + AW'(1);
          if (cnt_r == LAST_A) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_id0_on_r  <= RST_COLOR_ID0;
      color_id0_off_r <= RST_COLOR_ID0;
      color_id1_on_r  <= RST_COLOR_ID1;
      color_id1_off_r <= RST_COLOR_ID1;
      background_r    <= RST_BACKGROUND;
      decay_step_r    <= RST_DECAY_STEP;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_COLOR_ID0_ON:  color_id0_on_r  <= cfg_wdata;
        REG_COLOR_ID0_OFF: color_id0_off_r <= cfg_wdata;
        REG_COLOR_ID1_ON:  color_id1_on_r  <= cfg_wdata;
        REG_COLOR_ID1_OFF: color_id1_off_r <= cfg_wdata;
        REG_BACKGROUND:    background_r    <= cfg_wdata;
        REG_DECAY_STEP:    decay_step_r    <= cfg_wdata[COMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_zero_r ? '0 : rd_data_r[2*COMP_W +: COMP_W];
  assign out_green = out_zero_r ? '0 : rd_data_r[COMP_W +: COMP_W];
  assign out_blue  = out_zero_r ? '0 : rd_data_r[0 +: COMP_W];

  // result only for a read taken the cycle before
  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(start && !busy && in_opcode == OP_READ))
    else $error("result without accepted read");

  // sweep write-back only follows a sweep read
  a_writeback_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    sw_valid_r |-> $past(state_r == ST_SWEEP))
    else $error("write-back outside sweep");

  // write-back trails the read pointer by exactly one entry
  a_writeback_lag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && sw_valid_r) |-> (cnt_r == sw_addr_r + AW'(1)))
    else $error("sweep write-back address out of step");

  // no transaction is taken while the frame is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> !out_valid_r)
    else $error("result during clearing pass");

endmodule

### sv/efdb_pixel_decay.sv
// One decay step on a pixel: each component moves toward the background
// by the step and snaps to it when within one step. Uses efdb_pkg.
module efdb_pixel_decay
  import efdb_pkg::*;
(
  input  pixel_t pix_in,
  input  pixel_t background,
  input  comp_t  step,
  output pixel_t pix_out
);

  for (genvar g = 0; g < NUM_COMP; g++) begin : g_comp
    logic [COMP_W-1:0] cur;
    logic [COMP_W-1:0] tgt;
    logic [COMP_W:0]   tgt_plus;
    logic [COMP_W:0]   cur_plus;
    logic [COMP_W-1:0] res;

    assign cur      = pix_in[g*COMP_W +: COMP_W];
    assign tgt      = background[g*COMP_W +: COMP_W];
    assign tgt_plus = {1'b0, tgt} + {1'b0, step};
    assign cur_plus = {1'b0, cur} + {1'b0, step};

    always_comb begin
      if ({1'b0, cur} >= tgt_plus) begin
        res = cur - step;
      end else if (cur_plus <= {1'b0, tgt}) begin
        res = cur_plus[COMP_W-1:0];
      end else begin
        res = tgt;
      end
    end

    assign pix_out[g*COMP_W +: COMP_W] = res;
  end

endmodule
